// ===== rtl/core/lcdseq_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Types, codes and the microprogram for the character LCD nibble sequencer.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

	localparam int PC_W = 6;

	// request codes
	localparam logic [2:0] CMD_INIT   = 3'd0;
	localparam logic [2:0] CMD_BYTE   = 3'd1;
	localparam logic [2:0] CMD_CHAR   = 3'd2;
	localparam logic [2:0] CMD_CLEAR  = 3'd3;
	localparam logic [2:0] CMD_CURSOR = 3'd4;

	// result kinds
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_SHORT = 2'd1;
	localparam logic [1:0] KIND_LONG  = 2'd2;

	// nibble source
	localparam logic [1:0] SEL_CONST = 2'd0;
	localparam logic [1:0] SEL_OP_HI = 2'd1;
	localparam logic [1:0] SEL_OP_LO = 2'd2;

	// sequencing
	localparam logic [1:0] FLOW_NEXT = 2'd0;
	localparam logic [1:0] FLOW_END  = 2'd1;
	localparam logic [1:0] FLOW_COND = 2'd2;

	// program entry points
	localparam logic [PC_W-1:0] ENTRY_INIT = 6'd0;
	localparam logic [PC_W-1:0] ENTRY_OP   = 6'd42;
	localparam logic [PC_W-1:0] ENTRY_LONG = 6'd48;

	// expander bits
	localparam logic [7:0] LINE2_BASE = 8'h40;
	localparam logic [7:0] DDRAM_SET  = 8'h80;
	localparam logic [7:0] CLEAR_BYTE = 8'h01;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] sel;
		logic       en;
		logic [3:0] nib;
		logic [1:0] flow;
	} uword_t;

	typedef struct packed {
		logic   run;
		logic   fin;
		uword_t uw;
	} useq_stat_t;

	function automatic uword_t mk_uw(logic [1:0] kind, logic [1:0] sel, logic en,
			logic [3:0] nib, logic [1:0] flow);
		uword_t w;
		w.kind = kind;
		w.sel  = sel;
		w.en   = en;
		w.nib  = nib;
		w.flow = flow;
		return w;
	endfunction

	// Init runs 0..41, the shared byte routine 42..47, the trailing long wait 48.
	function automatic uword_t ucode_rom(logic [PC_W-1:0] pc);
		uword_t w;
		case (pc)
			6'd0:
				w = mk_uw(KIND_LONG, SEL_CONST, 1'b0, 4'h0, FLOW_NEXT);
			6'd1, 6'd3, 6'd5, 6'd7, 6'd9, 6'd11:
				w = mk_uw(KIND_WRITE, SEL_CONST, 1'b0, 4'h3, FLOW_NEXT);
			6'd2, 6'd6, 6'd10:
				w = mk_uw(KIND_WRITE, SEL_CONST, 1'b1, 4'h3, FLOW_NEXT);
			6'd4, 6'd8, 6'd12, 6'd16:
				w = mk_uw(KIND_SHORT, SEL_CONST, 1'b0, 4'h0, FLOW_NEXT);
			6'd13, 6'd15, 6'd17, 6'd19:
				w = mk_uw(KIND_WRITE, SEL_CONST, 1'b0, 4'h2, FLOW_NEXT);
			6'd14, 6'd18:
				w = mk_uw(KIND_WRITE, SEL_CONST, 1'b1, 4'h2, FLOW_NEXT);
			6'd20, 6'd22:
				w = mk_uw(KIND_WRITE, SEL_CONST, 1'b0, 4'h8, FLOW_NEXT);
			6'd21:
				w = mk_uw(KIND_WRITE, SEL_CONST, 1'b1, 4'h8, FLOW_NEXT);
			6'd23, 6'd25, 6'd29, 6'd31, 6'd35, 6'd37:
				w = mk_uw(KIND_WRITE, SEL_CONST, 1'b0, 4'h0, FLOW_NEXT);
			6'd24, 6'd30, 6'd36:
				w = mk_uw(KIND_WRITE, SEL_CONST, 1'b1, 4'h0, FLOW_NEXT);
			6'd26, 6'd28:
				w = mk_uw(KIND_WRITE, SEL_CONST, 1'b0, 4'hC, FLOW_NEXT);
			6'd27:
				w = mk_uw(KIND_WRITE, SEL_CONST, 1'b1, 4'hC, FLOW_NEXT);
			6'd32, 6'd34:
				w = mk_uw(KIND_WRITE, SEL_CONST, 1'b0, 4'h6, FLOW_NEXT);
			6'd33:
				w = mk_uw(KIND_WRITE, SEL_CONST, 1'b1, 4'h6, FLOW_NEXT);
			6'd38, 6'd40:
				w = mk_uw(KIND_WRITE, SEL_CONST, 1'b0, 4'h1, FLOW_NEXT);
			6'd39:
				w = mk_uw(KIND_WRITE, SEL_CONST, 1'b1, 4'h1, FLOW_NEXT);
			6'd41:
				w = mk_uw(KIND_LONG, SEL_CONST, 1'b0, 4'h0, FLOW_END);
			6'd42, 6'd44:
				w = mk_uw(KIND_WRITE, SEL_OP_HI, 1'b0, 4'h0, FLOW_NEXT);
			6'd43:
				w = mk_uw(KIND_WRITE, SEL_OP_HI, 1'b1, 4'h0, FLOW_NEXT);
			6'd45:
				w = mk_uw(KIND_WRITE, SEL_OP_LO, 1'b0, 4'h0, FLOW_NEXT);
			6'd46:
				w = mk_uw(KIND_WRITE, SEL_OP_LO, 1'b1, 4'h0, FLOW_NEXT);
			6'd47:
				w = mk_uw(KIND_WRITE, SEL_OP_LO, 1'b0, 4'h0, FLOW_COND);
			6'd48:
				w = mk_uw(KIND_LONG, SEL_CONST, 1'b0, 4'h0, FLOW_END);
			default:
				w = mk_uw(KIND_LONG, SEL_CONST, 1'b0, 4'h0, FLOW_END);
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/core/lcdseq_useq.sv =====
// ----------------------------------------------------------------------------
// lcdseq_useq
// Step counter and microprogram ROM with conditional jump to the long wait.
// ----------------------------------------------------------------------------
module lcdseq_useq import lcdseq_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  logic [PC_W-1:0] entry,
	input  logic            cond,
	output useq_stat_t      stat
);

	logic [PC_W-1:0] pc_q;
	logic            run_q;
	uword_t          uw;
	logic            fin;
	logic            take_jump;

	assign uw        = ucode_rom(pc_q);
	assign take_jump = (uw.flow == FLOW_COND) && cond;
	assign fin       = run_q && ((uw.flow == FLOW_END) || ((uw.flow == FLOW_COND) && !cond));

	assign stat.run = run_q;
	assign stat.fin = fin;
	assign stat.uw  = uw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= ENTRY_INIT;
			run_q <= 1'b0;
		end else if (load) begin
			pc_q  <= entry;
			run_q <= 1'b1;
		end else if (run_q) begin
			if (fin) begin
				run_q <= 1'b0;
			end else if (take_jump) begin
				pc_q <= ENTRY_LONG;
			end else begin
				pc_q <= PC_W'(pc_q + 1'b1);
			end
		end
	end

endmodule

// ===== rtl/core/char_lcd_nibble_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_core
// Turns LCD requests into expander byte words for a 4-bit HD44780 interface.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  request   in         start / busy         cmd, value, row, column
//  result    out        strobe (no backpressure)  kind, expander_byte, last
//
// Cycles: one result word per clock while a run is active; the step counter
// walking the microprogram ROM sets that pace. A byte request (command,
// character, set cursor) runs the byte routine, clear adds the long wait.
// The next request is taken in the cycle that issues the last step, so runs
// follow back to back. Undefined codes (5..7) are taken and produce nothing.
// Reset: arst_n clears the step counter, the run flag and the strobe.
// Stalls: none, the receiver must take every word in its strobe cycle.
//
module char_lcd_nibble_sequencer_core import lcdseq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] cmd,
	input  logic [7:0] value,
	input  logic       row,
	input  logic [5:0] column,
	output logic       strobe,
	output logic [1:0] kind,
	output logic [7:0] expander_byte,
	output logic       last
);

	useq_stat_t      stat;
	logic            accept;
	logic            cmd_ok;
	logic            load;
	logic [PC_W-1:0] entry;
	logic [7:0]      op_byte;
	logic [6:0]      cursor_addr;

	logic [7:0]      op_q;
	logic            rs_q;
	logic            long_q;

	logic [3:0]      nib;
	logic            rs_bit;
	logic [7:0]      byte_d;

	logic            strobe_q;
	logic [1:0]      kind_q;
	logic [7:0]      byte_q;
	logic            last_q;

	// Take a new request when idle or in the final step of the current run.
	assign busy   = stat.run && !stat.fin;
	assign accept = start && !busy;
	assign cmd_ok = (cmd == CMD_INIT) || (cmd == CMD_BYTE) || (cmd == CMD_CHAR) ||
			(cmd == CMD_CLEAR) || (cmd == CMD_CURSOR);
	assign load   = accept && cmd_ok;
	assign entry  = (cmd == CMD_INIT) ? ENTRY_INIT : ENTRY_OP;

	// Line base plus column never exceeds seven bits.
	assign cursor_addr = {row, 6'd0} + {1'b0, column};

	always_comb begin
		case (cmd)
			CMD_BYTE, CMD_CHAR: op_byte = value;
			CMD_CLEAR:          op_byte = CLEAR_BYTE;
			CMD_CURSOR:         op_byte = DDRAM_SET | {1'b0, cursor_addr};
			default:            op_byte = 8'h00;
		endcase
	end

	// Latch the operand byte and flags; payload needs no reset.
	always_ff @(posedge clk) begin
		if (load) begin
			op_q   <= op_byte;
			rs_q   <= (cmd == CMD_CHAR);
			long_q <= (cmd == CMD_CLEAR);
		end
	end

	lcdseq_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.entry  (entry),
		.cond   (long_q),
		.stat   (stat)
	);

	// Datapath: pick the nibble, add backlight, enable and register select.
	always_comb begin
		case (stat.uw.sel)
			SEL_OP_HI: nib = op_q[7:4];
			SEL_OP_LO: nib = op_q[3:0];
			default:   nib = stat.uw.nib;
		endcase
	end

	assign rs_bit = rs_q && (stat.uw.sel != SEL_CONST);
	assign byte_d = (stat.uw.kind == KIND_WRITE) ? {nib, 1'b1, stat.uw.en, 1'b0, rs_bit} : 8'h00;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= stat.run;
		end
	end

	// Hold the result word for its single strobe cycle.
	always_ff @(posedge clk) begin
		if (stat.run) begin
			kind_q <= stat.uw.kind;
			byte_q <= byte_d;
			last_q <= stat.fin;
		end
	end

	assign strobe        = strobe_q;
	assign kind          = kind_q;
	assign expander_byte = byte_q;
	assign last          = last_q;

`ifndef ASSERT_OFF
	a_bad_cmd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cmd_ok) |=> !stat.run)
		else $error("undefined request started a run");

	a_run_strobes: assert property (@(posedge clk) disable iff (!arst_n)
		stat.run |=> strobe)
		else $error("active step gave no result word");

	a_wait_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && kind != KIND_WRITE) |-> (expander_byte == 8'h00))
		else $error("wait word carries a byte");

	a_backlight: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && kind == KIND_WRITE) |-> expander_byte[3])
		else $error("expander write without backlight");

	a_fin_last: assert property (@(posedge clk) disable iff (!arst_n)
		stat.fin |=> (strobe && last))
		else $error("final step not marked last");
`endif

endmodule

// ===== tb/lcd_word_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_word_checker
// Watches the request and result channels of the LCD nibble sequencer,
// predicts the expander word run for every accepted request and compares
// each result word, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module lcd_word_checker import lcdseq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  logic [2:0] cmd,
	input  logic [7:0] value,
	input  logic       row,
	input  logic [5:0] column,
	input  logic       strobe,
	input  logic [1:0] kind,
	input  logic [7:0] expander_byte,
	input  logic       last,
	output int         mismatches,
	output int         outstanding,
	output int         words_seen
);

	localparam logic [7:0] BACKLIGHT = 8'h08;
	localparam logic [7:0] ENABLE    = 8'h04;
	localparam logic [7:0] REG_SEL   = 8'h01;
	localparam logic [7:0] NIB_MASK  = 8'hF0;

	// power-up wake nibbles and the set-up commands that follow them
	localparam logic [7:0] WAKE_NIB  = 8'h30;
	localparam logic [7:0] MODE4_NIB = 8'h20;
	localparam logic [7:0] FUNC_SET  = 8'h28;
	localparam logic [7:0] DISP_ON   = 8'h0C;
	localparam logic [7:0] ENTRY_SET = 8'h06;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] xbyte;
		logic       last;
	} lcd_word_t;

	lcd_word_t expected_words[$];
	int        error_total = 0;
	int        word_total  = 0;

	function automatic void queue_word(logic [1:0] k, logic [7:0] b);
		lcd_word_t w;
		w.kind  = k;
		w.xbyte = b;
		w.last  = 1'b0;
		expected_words.push_back(w);
	endfunction

	// one nibble: plain, enable high, enable dropped
	function automatic void queue_nibble(logic [7:0] bits);
		queue_word(KIND_WRITE, bits | BACKLIGHT);
		queue_word(KIND_WRITE, bits | ENABLE | BACKLIGHT);
		queue_word(KIND_WRITE, (bits & ~ENABLE) | BACKLIGHT);
	endfunction

	function automatic void queue_byte(logic [7:0] val, logic [7:0] rs);
		queue_nibble((val & NIB_MASK) | rs);
		queue_nibble({val[3:0], 4'h0} | rs);
	endfunction

	function automatic void predict_request(logic [2:0] c, logic [7:0] v, logic r,
			logic [5:0] col);
		int        base_size;
		lcd_word_t w;
		base_size = expected_words.size();
		case (c)
			CMD_INIT: begin
				queue_word(KIND_LONG, 8'h00);
				for (int i = 0; i < 3; i++) begin
					queue_nibble(WAKE_NIB);
					queue_word(KIND_SHORT, 8'h00);
				end
				queue_nibble(MODE4_NIB);
				queue_word(KIND_SHORT, 8'h00);
				queue_byte(FUNC_SET, 8'h00);
				queue_byte(DISP_ON, 8'h00);
				queue_byte(ENTRY_SET, 8'h00);
				queue_byte(CLEAR_BYTE, 8'h00);
				queue_word(KIND_LONG, 8'h00);
			end
			CMD_BYTE:
				queue_byte(v, 8'h00);
			CMD_CHAR:
				queue_byte(v, REG_SEL);
			CMD_CLEAR: begin
				queue_byte(CLEAR_BYTE, 8'h00);
				queue_word(KIND_LONG, 8'h00);
			end
			CMD_CURSOR:
				queue_byte(DDRAM_SET | ((r ? LINE2_BASE : 8'h00) + {2'b00, col}), 8'h00);
			default: ;
		endcase
		// flag the closing word of the run
		if (expected_words.size() > base_size) begin
			w = expected_words.pop_back();
			w.last = 1'b1;
			expected_words.push_back(w);
		end
	endfunction

	always @(posedge clk) begin : watch
		lcd_word_t want;
		if (arst_n) begin
			// words from earlier runs come before anything accepted at this edge
			if (strobe) begin
				word_total++;
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word: expected none, actual kind %0d byte %h last %b",
						$time, kind, expander_byte, last);
					error_total++;
				end else begin
					want = expected_words.pop_front();
					if (kind !== want.kind) begin
						$display("%0t: kind mismatch: expected %0d, actual %0d",
							$time, want.kind, kind);
						error_total++;
					end
					if (expander_byte !== want.xbyte) begin
						$display("%0t: expander byte mismatch: expected %h, actual %h",
							$time, want.xbyte, expander_byte);
						error_total++;
					end
					if (last !== want.last) begin
						$display("%0t: last mismatch: expected %b, actual %b",
							$time, want.last, last);
						error_total++;
					end
				end
			end
			if (start && !busy)
				predict_request(cmd, value, row, column);
			mismatches  <= error_total;
			outstanding <= expected_words.size();
			words_seen  <= word_total;
		end
	end

endmodule

// ===== tb/char_lcd_nibble_sequencer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_core_tb
// Drives LCD requests into the nibble sequencer, directed corners first and
// then random runs under varying request gaps; a checker beside the block
// predicts every expander word and counts mismatches for the verdict.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_core_tb;
	import lcdseq_pkg::*;

	// codes past set cursor are undefined and must be swallowed silently
	localparam logic [2:0] CMD_UNDEF_LO = 3'd5;
	localparam logic [2:0] CMD_UNDEF_HI = 3'd7;

	localparam int ITEMS_PER_PHASE = 26;
	localparam int DRAIN_CYCLES    = 20;
	// cycles with neither a request nor a word taken; the longest legal
	// quiet stretch is a handful of request gaps, so this is generous
	localparam int WATCHDOG_LIMIT  = 1000;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [2:0] cmd;
	logic [7:0] value;
	logic       row;
	logic [5:0] column;
	logic       strobe;
	logic [1:0] kind;
	logic [7:0] expander_byte;
	logic       last;

	int mismatches;
	int outstanding;
	int words_seen;

	int idle_pct    = 0;
	int quiet_count = 0;
	int n_init      = 0;
	int n_byte      = 0;
	int n_char      = 0;
	int n_clear     = 0;
	int n_cursor    = 0;
	int n_undef     = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	char_lcd_nibble_sequencer_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.value         (value),
		.row           (row),
		.column        (column),
		.strobe        (strobe),
		.kind          (kind),
		.expander_byte (expander_byte),
		.last          (last)
	);

	lcd_word_checker word_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.value         (value),
		.row           (row),
		.column        (column),
		.strobe        (strobe),
		.kind          (kind),
		.expander_byte (expander_byte),
		.last          (last),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.words_seen    (words_seen)
	);

	// Watchdog: reset the count on any request or word taken, abort when the
	// block has gone quiet for far too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || strobe)
				quiet_count <= 0;
			else
				quiet_count <= quiet_count + 1;
			if (quiet_count >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired, nothing moving", $time);
				$display("char_lcd_nibble_sequencer_core verification failed");
				$finish;
			end
		end
	end

	// Present one request word at the falling edge and hold it until the
	// block takes it. Called at a falling edge, returns at a falling edge with
	// start still high, so the next request can follow without a gap.
	task automatic send_request(input logic [2:0] c, input logic [7:0] v, input logic r,
			input logic [5:0] col);
		// random gaps: drop start and wiggle the payload so that stale
		// fields are never mistaken for a request
		while ($urandom_range(99) < idle_pct) begin
			start  = 1'b0;
			cmd    = 3'($urandom);
			value  = 8'($urandom);
			row    = 1'($urandom);
			column = 6'($urandom);
			@(negedge clk);
		end
		start  = 1'b1;
		cmd    = c;
		value  = v;
		row    = r;
		column = col;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		case (c)
			CMD_INIT:   n_init++;
			CMD_BYTE:   n_byte++;
			CMD_CHAR:   n_char++;
			CMD_CLEAR:  n_clear++;
			CMD_CURSOR: n_cursor++;
			default:    n_undef++;
		endcase
		@(negedge clk);
	endtask

	// Hold off the sender until every predicted word has come out.
	task automatic wait_drained();
		start = 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Random request mix: mostly character and command bytes with random
	// content, cursor moves across both lines, the odd init or clear, and a
	// sprinkling of undefined codes as noise.
	task automatic send_random();
		int         pick;
		logic [2:0] c;
		pick = $urandom_range(99);
		if (pick < 4)
			c = CMD_INIT;
		else if (pick < 9)
			c = CMD_CLEAR;
		else if (pick < 14)
			c = 3'($urandom_range(CMD_UNDEF_HI, CMD_UNDEF_LO));
		else if (pick < 48)
			c = CMD_CHAR;
		else if (pick < 72)
			c = CMD_BYTE;
		else
			c = CMD_CURSOR;
		send_request(c, 8'($urandom), 1'($urandom), 6'($urandom));
	endtask

	initial begin : stimulus
		int counted;
		arst_n = 1'b0;
		start  = 1'b0;
		cmd    = CMD_INIT;
		value  = 8'h00;
		row    = 1'b0;
		column = 6'd0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed corners, back to back: init with junk in the unused
		// fields, byte extremes for command and character, clear, cursor at
		// both ends of both lines, and every undefined code.
		idle_pct = 0;
		send_request(CMD_INIT, 8'hFF, 1'b1, 6'd63);
		send_request(CMD_BYTE, 8'h00, 1'b1, 6'd63);
		send_request(CMD_BYTE, 8'hFF, 1'b0, 6'd0);
		send_request(CMD_CHAR, 8'h00, 1'b1, 6'd21);
		send_request(CMD_CHAR, 8'hFF, 1'b0, 6'd42);
		send_request(CMD_CHAR, 8'hA5, 1'b1, 6'd0);
		send_request(CMD_BYTE, 8'h5A, 1'b0, 6'd63);
		send_request(CMD_CLEAR, 8'hFF, 1'b1, 6'd63);
		send_request(CMD_CURSOR, 8'hFF, 1'b0, 6'd0);
		send_request(CMD_CURSOR, 8'h00, 1'b1, 6'd63);
		send_request(CMD_CURSOR, 8'h00, 1'b0, 6'd63);
		send_request(CMD_CURSOR, 8'hFF, 1'b1, 6'd0);
		send_request(CMD_UNDEF_LO, 8'hFF, 1'b1, 6'd63);
		send_request(CMD_UNDEF_LO + 3'd1, 8'h00, 1'b0, 6'd0);
		send_request(CMD_UNDEF_HI, 8'h3C, 1'b1, 6'd42);
		// an undefined code straight into a real one
		send_request(CMD_CHAR, 8'h81, 1'b0, 6'd1);
		send_request(CMD_CLEAR, 8'h00, 1'b0, 6'd0);
		send_request(CMD_INIT, 8'h00, 1'b0, 6'd0);

		// let the block run dry once before the random part
		wait_drained();

		// three random phases: light request gaps, heavy gaps, none at all
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 18 : (phase == 1) ? 49 : 0;
			counted  = 0;
			while (counted < ITEMS_PER_PHASE) begin
				send_random();
				if (cmd <= CMD_CURSOR)
					counted++;
			end
		end

		// drain, then idle for DRAIN_CYCLES so that anything stray can show up
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d requests: %0d init, %0d cmd, %0d char, %0d clear, %0d cursor, %0d undef",
			n_init + n_byte + n_char + n_clear + n_cursor + n_undef,
			n_init, n_byte, n_char, n_clear, n_cursor, n_undef);
		$display("Checked %0d expander words, %0d still awaited", words_seen, outstanding);
		if (mismatches == 0 && outstanding == 0)
			$display("char_lcd_nibble_sequencer_core verification clean");
		else
			$display("char_lcd_nibble_sequencer_core verification failed");
		$finish;
	end

endmodule
